// ===== design/rtsp_response_header_parser_core_macros.svh =====
// Assertion macros used by the checker file of the RTSP header parser.
`ifndef RTSP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH
`define RTSP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH

// Condition and consequence checked at the same clock edge.
`define RHP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked at the clock edge after the condition.
`define RHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rhp_pkg.sv =====
// Types, character codes and prefix tables for the RTSP response header parser.
`default_nettype none

package rhp_pkg;

  localparam int NUM_PFX = 4;

  // Input and result words
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } rhp_in_t;

  typedef struct packed {
    logic signed [31:0] reply_status;
    logic signed [31:0] sequence_number;
    logic signed [31:0] session_number;
    logic signed [31:0] body_length;
    logic               header_complete;
    logic [15:0]        header_bytes;
  } rhp_out_t;

  // Prefix matcher status toward the parser
  typedef struct packed {
    logic [NUM_PFX-1:0] alive;
    logic               hit;
    logic [1:0]         idx;
  } rhp_match_t;

  // Line parse phase
  typedef enum logic [3:0] {
    PH_LINE   = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_REST   = 4'b1000
  } rhp_phase_t;

  // Value slots, also the prefix order
  localparam logic [1:0] FLD_STATUS  = 2'd0;
  localparam logic [1:0] FLD_SEQ     = 2'd1;
  localparam logic [1:0] FLD_SESSION = 2'd2;
  localparam logic [1:0] FLD_LENGTH  = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Magnitude limits
  localparam logic [31:0] ACC_MAX = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  // Prefix texts in upper case, right-justified
  localparam logic [127:0] PFX_STATUS  = "RTSP/1.0";
  localparam logic [127:0] PFX_SEQ     = "CSEQ:";
  localparam logic [127:0] PFX_SESSION = "SESSION:";
  localparam logic [127:0] PFX_LENGTH  = "CONTENT-LENGTH:";

  function automatic logic [7:0] up_ascii(input logic [7:0] c);
    return (c >= CH_A_LO && c <= CH_Z_LO) ? c - CASE_OFS : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic [3:0] pfx_len(input logic [1:0] k);
    logic [3:0] len;
    unique case (k)
      FLD_STATUS:  len = 4'd8;
      FLD_SEQ:     len = 4'd5;
      FLD_SESSION: len = 4'd8;
      FLD_LENGTH:  len = 4'd15;
      default:     len = 4'd15;
    endcase
    return len;
  endfunction

  // Character of prefix k at a column below its length
  function automatic logic [7:0] pfx_char(input logic [1:0] k, input logic [3:0] col);
    logic [127:0] txt;
    logic [3:0]   pos;
    unique case (k)
      FLD_STATUS:  txt = PFX_STATUS;
      FLD_SEQ:     txt = PFX_SEQ;
      FLD_SESSION: txt = PFX_SESSION;
      FLD_LENGTH:  txt = PFX_LENGTH;
      default:     txt = PFX_LENGTH;
    endcase
    pos = pfx_len(k) - 4'd1 - col;
    return txt[{pos, 3'b000} +: 8];
  endfunction

  // Signed value from sign and saturated magnitude
  function automatic logic [31:0] sat_value(input logic neg, input logic [31:0] acc);
    if (neg) begin
      return 32'd0 - acc;
    end
    return acc[31] ? POS_MAX : acc;
  endfunction

endpackage

`default_nettype wire

// ===== design/rhp_prefix_match.sv =====
// Case-insensitive prefix compare of one byte against the four header prefixes.
`default_nettype none

module rhp_prefix_match (
  input  logic [3:0]                     column,
  input  logic [rhp_pkg::NUM_PFX-1:0]    alive,
  input  logic [7:0]                     text_byte,
  output rhp_pkg::rhp_match_t            match
);
  import rhp_pkg::*;

  logic [7:0]         up_byte;
  logic [NUM_PFX-1:0] keep;

  assign up_byte = up_ascii(text_byte);

  // Drop prefixes that end before this column or differ here
  always_comb begin
    for (int k = 0; k < NUM_PFX; k++) begin
      keep[k] = alive[k] && (column < pfx_len(2'(k))) &&
                (pfx_char(2'(k), column) == up_byte);
    end
  end

  // Full match on the last character; lowest index wins
  always_comb begin
    match.alive = keep;
    match.hit   = 1'b0;
    match.idx   = FLD_STATUS;
    for (int k = NUM_PFX - 1; k >= 0; k--) begin
      if (keep[k] && (({1'b0, column} + 5'd1) == {1'b0, pfx_len(2'(k))})) begin
        match.hit = 1'b1;
        match.idx = 2'(k);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rhp_parser.sv =====
// Per-byte parse state: line phases, number accumulation, value slots, byte count.
`default_nettype none

module rhp_parser #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              word_vld,
  input  rhp_pkg::rhp_in_t  word,
  input  logic              take,
  output logic              emit,
  output rhp_pkg::rhp_out_t result
);
  import rhp_pkg::*;

  rhp_phase_t         phase_r, phase_nxt;
  logic [3:0]         column_r, column_nxt;
  logic [NUM_PFX-1:0] alive_r, alive_nxt;
  logic [1:0]         target_r, target_nxt;
  logic               neg_r, neg_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [31:0]        vals_r [NUM_PFX];
  logic [31:0]        vals_nxt [NUM_PFX];
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic               done_r, done_nxt;
  logic               cr_r, cr_nxt;

  rhp_match_t  pm;
  logic [7:0]  b;
  logic        is_digit;
  logic [35:0] prod;
  logic [31:0] acc_dig;
  logic        end_line;
  logic        lf_emit;
  logic [15:0] hdr_bytes;

  assign b = word.text_byte;

  rhp_prefix_match u_pm (
    .column    (column_r),
    .alive     (alive_r),
    .text_byte (b),
    .match     (pm)
  );

  // Decimal step: acc * 10 + digit, saturating at 2^31
  assign is_digit = (b >= CH_0) && (b <= CH_9);
  assign prod     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, b[3:0]};
  assign acc_dig  = (prod > {4'd0, ACC_MAX}) ? ACC_MAX : prod[31:0];

  // CR LF pair closes the line; a line of CR alone closes the header
  assign end_line = !done_r && cr_r && (b == CH_LF);
  assign lf_emit  = end_line && (column_r == 4'd1);
  assign emit     = word_vld && (lf_emit || (word.final_byte && !done_r));

  // Byte count, saturating
  always_comb begin
    count_nxt = count_r;
    if (!done_r && count_r != '1) begin
      count_nxt = count_r + COUNT_BITS'(1);
    end
  end

  generate
    if (COUNT_BITS > 16) begin : g_wide_count
      assign hdr_bytes = (|count_nxt[COUNT_BITS-1:16]) ? 16'hFFFF : count_nxt[15:0];
    end else begin : g_narrow_count
      assign hdr_bytes = 16'(count_nxt);
    end
  endgenerate

  // Parse step for one byte
  always_comb begin
    phase_nxt  = phase_r;
    column_nxt = column_r;
    alive_nxt  = alive_r;
    target_nxt = target_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    vals_nxt   = vals_r;
    done_nxt   = done_r;
    cr_nxt     = cr_r;
    if (end_line) begin
      done_nxt   = lf_emit;
      phase_nxt  = PH_LINE;
      column_nxt = 4'd0;
      alive_nxt  = '1;
      target_nxt = FLD_STATUS;
      neg_nxt    = 1'b0;
      acc_nxt    = 32'd0;
      cr_nxt     = 1'b0;
    end else if (!done_r) begin
      unique case (phase_r)
        PH_LINE: begin
          alive_nxt = pm.alive;
          if (pm.hit) begin
            target_nxt       = pm.idx;
            neg_nxt          = 1'b0;
            acc_nxt          = 32'd0;
            vals_nxt[pm.idx] = 32'd0;
            phase_nxt        = PH_SKIP;
          end else if (pm.alive == '0) begin
            phase_nxt = PH_REST;
          end
        end
        PH_SKIP: begin
          priority if (is_space(b)) begin
            phase_nxt = PH_SKIP;
          end else if (b == CH_PLUS || b == CH_MINUS) begin
            neg_nxt   = (b == CH_MINUS);
            phase_nxt = PH_DIGITS;
          end else if (is_digit) begin
            acc_nxt            = acc_dig;
            vals_nxt[target_r] = sat_value(neg_r, acc_dig);
            phase_nxt          = PH_DIGITS;
          end else begin
            phase_nxt = PH_REST;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc_nxt            = acc_dig;
            vals_nxt[target_r] = sat_value(neg_r, acc_dig);
          end else begin
            phase_nxt = PH_REST;
          end
        end
        PH_REST: phase_nxt = PH_REST;
        default: phase_nxt = PH_REST;
      endcase
      column_nxt = (column_r != 4'd15) ? column_r + 4'd1 : column_r;
      cr_nxt     = (b == CH_CR);
    end
  end

  // Result fields after this byte
  always_comb begin
    result.reply_status    = vals_nxt[FLD_STATUS];
    result.sequence_number = vals_nxt[FLD_SEQ];
    result.session_number  = vals_nxt[FLD_SESSION];
    result.body_length     = vals_nxt[FLD_LENGTH];
    result.header_complete = lf_emit;
    result.header_bytes    = hdr_bytes;
  end

  // State registers; the final byte returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n || (take && word.final_byte)) begin
      phase_r  <= PH_LINE;
      column_r <= 4'd0;
      alive_r  <= '1;
      target_r <= FLD_STATUS;
      neg_r    <= 1'b0;
      acc_r    <= 32'd0;
      for (int i = 0; i < NUM_PFX; i++) begin
        vals_r[i] <= 32'd0;
      end
      count_r  <= '0;
      done_r   <= 1'b0;
      cr_r     <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      column_r <= column_nxt;
      alive_r  <= alive_nxt;
      target_r <= target_nxt;
      neg_r    <= neg_nxt;
      acc_r    <= acc_nxt;
      vals_r   <= vals_nxt;
      count_r  <= count_nxt;
      done_r   <= done_nxt;
      cr_r     <= cr_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/rhp_out_reg.sv =====
// Result register with valid/ready handshake toward the consumer.
`default_nettype none

module rhp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  rhp_pkg::rhp_out_t din,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output rhp_pkg::rhp_out_t out_data
);
  import rhp_pkg::*;

  logic     vld_r;
  rhp_out_t data_r;

  // Slot can take a word when empty or being drained this cycle
  assign free      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= din;
    end
  end

endmodule

`default_nettype wire

// ===== design/rtsp_response_header_parser_core.sv =====
// RTSP response header parser: one text byte per word, one result word per response.
// Throughput: one byte per clock, set by the line-state parse update, save the stall below.
// A byte is parsed from the input reg and its result offered from the result reg.
// A byte that causes a result waits in the input register while the result register is full.
// Reset: rst_n synchronous, active low; clears handshake state and all parse state.
`default_nettype none

module rtsp_response_header_parser_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rhp_pkg::rhp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rhp_pkg::rhp_out_t out_data
);
  import rhp_pkg::*;

  logic     in_vld_r;
  rhp_in_t  in_word_r;
  logic     emit;
  logic     fire;
  logic     out_free;
  rhp_out_t result;

  // Parse the held word unless its result has no place to go
  assign fire     = in_vld_r && (!emit || out_free);
  assign in_ready = !in_vld_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  rhp_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .word_vld (in_vld_r),
    .word     (in_word_r),
    .take     (fire),
    .emit     (emit),
    .result   (result)
  );

  rhp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && emit),
    .din       (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/rhp_checker.sv =====
// Port-level checker for the RTSP header parser, bound to the top level.
`default_nettype none
`include "rtsp_response_header_parser_core_macros.svh"

module rhp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rhp_pkg::rhp_out_t out_data
);

  // A stalled result stays offered
  `RHP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

  // A stalled result keeps its payload
  `RHP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data),
                   "result word changed while stalled")

  // A draining consumer never stalls the input side
  `RHP_ASSERT_SAME(a_no_stall, out_ready, in_ready, "input stalled while output drains")

  // Every result counts at least the byte that caused it
  `RHP_ASSERT_SAME(a_count_nonzero, out_valid, out_data.header_bytes != 16'd0,
                   "result with zero header length")

endmodule

bind rtsp_response_header_parser_core rhp_checker u_rhp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/rtsp_response_header_parser_core_test.sv =====
// Self-checking testbench for the RTSP response header parser core.
`default_nettype none

module rtsp_response_header_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rhp_pkg::*;

  localparam int          RANDOM_BYTES    = 1350;
  localparam int          MIN_RESPONSES   = 40;
  localparam int          SQUEEZE_CYCLES  = 400;
  localparam int          QUIET_LIMIT     = 4000;
  localparam int          DRAIN_CYCLES    = 20;
  localparam int          REPORT_LIMIT    = 10;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
  localparam logic [63:0] MAG_CLAMP       = 64'h8000_0000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rhp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rhp_out_t out_data;

  rtsp_response_header_parser_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Header results still owed by the block, oldest first
  rhp_out_t headers_due [$];
  int       fail_count = 0;
  int       sent_count = 0;
  bit       random_on = 1'b0;
  bit       squeeze = 1'b0;

  // ---------------------------------------------------------------------------
  // Header parse predictor
  // ---------------------------------------------------------------------------
  rhp_phase_t  ln_phase;
  logic [3:0]  ln_col;
  logic [3:0]  ln_alive;
  logic [1:0]  ln_target;
  logic        ln_neg;
  logic [31:0] ln_mag;
  logic [31:0] field_val [4];
  logic [15:0] hdr_count;
  logic        hdr_seen;
  logic        prev_cr;

  function automatic string prefix_of(int k);
    string p;
    case (k)
      FLD_STATUS:  p = "RTSP/1.0";
      FLD_SEQ:     p = "CSEQ:";
      FLD_SESSION: p = "SESSION:";
      default:     p = "CONTENT-LENGTH:";
    endcase
    return p;
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'h20 : c;
  endfunction

  function automatic logic blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic rhp_out_t mk_result(logic [31:0] st, logic [31:0] sq, logic [31:0] se,
                                         logic [31:0] ln, logic done, logic [15:0] cnt);
    rhp_out_t r;
    r.reply_status    = st;
    r.sequence_number = sq;
    r.session_number  = se;
    r.body_length     = ln;
    r.header_complete = done;
    r.header_bytes    = cnt;
    return r;
  endfunction

  function automatic void start_line();
    ln_phase  = PH_LINE;
    ln_col    = '0;
    ln_alive  = 4'hF;
    ln_target = '0;
    ln_neg    = 1'b0;
    ln_mag    = '0;
    prev_cr   = 1'b0;
  endfunction

  function automatic void clear_parser();
    for (int i = 0; i < 4; i++) field_val[i] = '0;
    hdr_count = '0;
    hdr_seen  = 1'b0;
    start_line();
  endfunction

  // Sign applied to the clamped magnitude
  function automatic logic [31:0] signed_value();
    if (ln_neg) begin
      return (ln_mag >= ACC_MAX) ? ACC_MAX : 32'd0 - ln_mag;
    end
    return (ln_mag >= ACC_MAX) ? POS_MAX : ln_mag;
  endfunction

  function automatic void take_digit(logic [7:0] b);
    logic [63:0] m;
    if (b >= CH_0 && b <= CH_9) begin
      m = 64'(ln_mag) * 64'd10 + 64'(b - CH_0);
      ln_mag = (m > MAG_CLAMP) ? MAG_CLAMP[31:0] : m[31:0];
      field_val[ln_target] = signed_value();
    end else begin
      ln_phase = PH_REST;
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    string p;
    bit    hit;
    hit = 1'b0;
    case (ln_phase)
      PH_LINE: begin
        // drop every prefix that this column rules out
        for (int k = 0; k < 4; k++) begin
          p = prefix_of(k);
          if (ln_alive[k] && (ln_col >= p.len() || fold(p[ln_col]) != fold(b)))
            ln_alive[k] = 1'b0;
        end
        // a prefix that ends here selects its value, cleared to zero
        for (int k = 0; k < 4; k++) begin
          p = prefix_of(k);
          if (!hit && ln_alive[k] && ln_col + 1 == p.len()) begin
            hit          = 1'b1;
            ln_target    = k[1:0];
            ln_neg       = 1'b0;
            ln_mag       = '0;
            field_val[k] = '0;
            ln_phase     = PH_SKIP;
          end
        end
        if (!hit && ln_alive == 4'h0) ln_phase = PH_REST;
      end
      PH_SKIP: begin
        if (!blank(b)) begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            ln_neg   = (b == CH_MINUS);
            ln_phase = PH_DIGITS;
          end else begin
            ln_phase = PH_DIGITS;
            take_digit(b);
          end
        end
      end
      PH_DIGITS: take_digit(b);
      default: ;
    endcase
  endfunction

  // One accepted input word; got tells whether a header result is due
  function automatic void parse_byte(rhp_in_t w, output bit got, output rhp_out_t res);
    got = 1'b0;
    res = '0;
    if (!hdr_seen) begin
      if (hdr_count != COUNT_MAX) hdr_count++;
      if (prev_cr && w.text_byte == CH_LF) begin
        // CR LF alone on a line closes the header
        if (ln_col == 4'd1) begin
          hdr_seen = 1'b1;
          got      = 1'b1;
          res      = mk_result(field_val[0], field_val[1], field_val[2], field_val[3],
                               1'b1, hdr_count);
        end
        start_line();
      end else begin
        scan_byte(w.text_byte);
        if (ln_col != 4'd15) ln_col++;
        prev_cr = (w.text_byte == CH_CR);
      end
    end
    if (w.final_byte) begin
      if (!got && !hdr_seen) begin
        got = 1'b1;
        res = mk_result(field_val[0], field_val[1], field_val[2], field_val[3],
                        1'b0, hdr_count);
      end
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void report(string what, rhp_out_t want, rhp_out_t got_w);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%s: expected st %0d seq %0d ses %0d len %0d done %0b bytes %0d", what,
               want.reply_status, want.sequence_number, want.session_number,
               want.body_length, want.header_complete, want.header_bytes);
      $display("  actual st %0d seq %0d ses %0d len %0d done %0b bytes %0d",
               got_w.reply_status, got_w.sequence_number, got_w.session_number,
               got_w.body_length, got_w.header_complete, got_w.header_bytes);
    end
  endfunction

  function automatic void check_result(rhp_out_t got_w);
    rhp_out_t want;
    if (headers_due.size() == 0) begin
      report("unexpected header result", '0, got_w);
      return;
    end
    want = headers_due.pop_front();
    if (got_w.reply_status !== want.reply_status ||
        got_w.sequence_number !== want.sequence_number ||
        got_w.session_number !== want.session_number ||
        got_w.body_length !== want.body_length ||
        got_w.header_complete !== want.header_complete ||
        got_w.header_bytes !== want.header_bytes)
      report("header result mismatch", want, got_w);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (squeeze || (sent_count / 128) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one word, then predict once it is taken
  task automatic offer(input rhp_in_t w, input bit typed, input bit yields,
                       input rhp_out_t want);
    int       gap;
    bit       got;
    rhp_out_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent_count++;
    parse_byte(w, got, res);
    if (typed) begin
      if (yields) headers_due.push_back(want);
    end else if (got) begin
      headers_due.push_back(res);
    end
  endtask

  // Directed words, with hand-read expectations on some rows
  typedef struct {
    rhp_in_t  word;
    bit       typed;
    bit       yields;
    rhp_out_t want;
  } plan_row_t;

  plan_row_t plan_rows [$];

  function automatic void add_row(logic [7:0] b, bit fin, bit typed, bit yields,
                                  rhp_out_t want);
    plan_row_t row;
    row.word.text_byte  = b;
    row.word.final_byte = fin;
    row.typed           = typed;
    row.yields          = yields;
    row.want            = want;
    plan_rows.push_back(row);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, 1'b0, '0);
  endfunction

  // Random response text
  logic [7:0] text_q [$];

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Any bytes, but never a CR LF pair
  function automatic void put_junk(int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_LF && text_q.size() > 0 && text_q[$] == CH_CR) c = "y";
      text_q.push_back(c);
    end
  endfunction

  function automatic void put_value_line(int k);
    string      p;
    logic [7:0] c;
    int         r;
    int         n;
    p = prefix_of(k);
    for (int i = 0; i < p.len(); i++) begin
      c = p[i];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + 8'h20;
      text_q.push_back(c);
    end
    // now and then a broken prefix
    if ($urandom_range(0, 9) == 0)
      text_q[text_q.size() - 1 - $urandom_range(0, p.len() - 1)] = 8'($urandom_range(65, 90));
    // blanks before the number
    r = $urandom_range(0, 9);
    n = (r < 5) ? 0 : (r < 8) ? 1 : $urandom_range(2, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: text_q.push_back(CH_SPACE);
        1: text_q.push_back(CH_TAB);
        2: text_q.push_back(CH_VT);
        3: text_q.push_back(CH_FF);
        4: text_q.push_back(CH_CR);
        default: text_q.push_back(CH_LF);
      endcase
    end
    r = $urandom_range(0, 9);
    if (r >= 8) text_q.push_back(CH_MINUS);
    else if (r >= 6) text_q.push_back(CH_PLUS);
    // digits: mostly short, some at the signed limits, a few far past them
    r = $urandom_range(0, 19);
    if (r == 2) begin
      case ($urandom_range(0, 4))
        0: put_str("2147483647");
        1: put_str("2147483648");
        2: put_str("2147483649");
        3: put_str("4294967296");
        default: put_str("0000000000002");
      endcase
    end else if (r >= 3) begin
      n = (r < 16) ? $urandom_range(1, 5) : (r < 19) ? $urandom_range(6, 10)
                                                     : $urandom_range(11, 14);
      for (int i = 0; i < n; i++) text_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 3) == 0) put_junk($urandom_range(1, 4));
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
  endfunction

  function automatic void build_response();
    int keep;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      put_junk($urandom_range(1, 16));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 9) < 7) begin
          put_value_line($urandom_range(0, 3));
        end else begin
          put_junk($urandom_range(1, 20));
          text_q.push_back(CH_CR);
          text_q.push_back(CH_LF);
        end
      end
      if ($urandom_range(0, 4) != 0) begin
        // empty line, then a short body that the block skips
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
        put_junk($urandom_range(0, 6));
      end else if (text_q.size() > 1 && $urandom_range(0, 1) == 1) begin
        keep = $urandom_range(1, text_q.size());
        while (text_q.size() > keep) void'(text_q.pop_back());
      end
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_response();
    rhp_in_t w;
    for (int i = 0; i < text_q.size(); i++) begin
      w.text_byte  = text_q[i];
      w.final_byte = (i == text_q.size() - 1);
      offer(w, 1'b0, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int rand_bytes;
    int responses;
    rand_bytes = 0;
    responses  = 0;
    clear_parser();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // byte extremes, empty header, ignored final, clamp, bare sign
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, mk_result(0, 0, 0, 0, 1'b0, 16'd1));
    add_row(CH_CR, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_LF, 1'b0, 1'b1, 1'b1, mk_result(0, 0, 0, 0, 1'b1, 16'd2));
    add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
    add_text("cseq:999999999");
    add_row("9", 1'b1, 1'b1, 1'b1, mk_result(0, POS_MAX, 0, 0, 1'b0, 16'd15));
    add_text("cseq:");
    add_row(CH_PLUS, 1'b1, 1'b1, 1'b1, mk_result(0, 0, 0, 0, 1'b0, 16'd6));
    foreach (plan_rows[i])
      offer(plan_rows[i].word, plan_rows[i].typed, plan_rows[i].yields, plan_rows[i].want);

    // random responses
    random_on = 1'b1;
    while (rand_bytes < RANDOM_BYTES || responses < MIN_RESPONSES) begin
      build_response();
      rand_bytes += text_q.size();
      send_response();
      responses++;
    end
    in_valid <= 1'b0;

    while (headers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && headers_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off
  // ---------------------------------------------------------------------------
  function automatic int pick_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  initial begin : result_side
    int cyc;
    int hold_left;
    bit squeezed;
    cyc       = 0;
    hold_left = 0;
    squeezed  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) check_result(out_data);
      cyc++;
      if (squeeze && hold_left == 0) squeeze = 1'b0;
      if (random_on && !squeezed) begin
        squeezed  = 1'b1;
        squeeze   = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ((cyc / 600) % 4 != 3) hold_left = pick_hold();
      end
    end
  end

  // Watchdog: too long with no word moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/rhp_pkg.sv
design/rhp_prefix_match.sv
design/rhp_parser.sv
design/rhp_out_reg.sv
design/rtsp_response_header_parser_core.sv
design/rhp_checker.sv
verif/rtsp_response_header_parser_core_test.sv
